// ===== src/assert_macros.svh =====
// Assertion helpers used by the stack manager unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define LZS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lzs assertion failed");

// Check that an expression never holds outside reset.
`define LZS_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lzs forbidden condition seen");

`else

`define LZS_ASSERT(label, clk, rst, prop)
`define LZS_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== src/lzs_pkg.sv =====
`timescale 1ns / 1ps

package lzs_pkg;

   localparam int unsigned LAYER_W        = 8;
   localparam int unsigned HEIGHT_W       = 9;
   localparam int unsigned HEIGHT_X_W     = HEIGHT_W + 1;
   localparam int unsigned CMD_W          = 2;
   localparam int unsigned NUM_LAYERS_DEF = 256;
   localparam int unsigned GROUP_SIZE     = 16;

   localparam logic signed [HEIGHT_W-1:0] HEIGHT_HIDDEN = -9'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_SET   = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NOP   = 2'd3
   } lzs_cmd_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } lzs_state_type;

   // one layer as seen by a lookup
   typedef struct packed {
      logic                        used;
      logic signed [HEIGHT_W-1:0]  height;
   } lzs_look_type;

   // lowest free layer seen so far along the chain
   typedef struct packed {
      logic               found;
      logic [LAYER_W-1:0] idx;
   } lzs_free_type;

   // update broadcast to every cell
   typedef struct packed {
      logic                         shift_en;
      logic                         up;
      logic signed [HEIGHT_X_W-1:0] lo;
      logic signed [HEIGHT_X_W-1:0] hi;
      logic                         tgt_we;
      logic [LAYER_W-1:0]           tgt_id;
      logic                         tgt_used;
      logic signed [HEIGHT_W-1:0]   tgt_height;
   } lzs_op_type;

endpackage

// ===== src/lzs_req_if.sv =====
`timescale 1ns / 1ps

interface lzs_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [7:0]        layer_id;
   logic signed [8:0] target_height;

   modport source (output valid, output cmd, output layer_id, output target_height,
                   input ready);
   modport sink   (input valid, input cmd, input layer_id, input target_height,
                   output ready);
endinterface

// ===== src/lzs_rsp_if.sv =====
`timescale 1ns / 1ps

interface lzs_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        result_layer;
   logic              pool_full;
   logic signed [8:0] final_height;
   logic signed [8:0] top_height;

   modport source (output valid, output result_layer, output pool_full,
                   output final_height, output top_height, input ready);
   modport sink   (input valid, input result_layer, input pool_full,
                   input final_height, input top_height, output ready);
endinterface

// ===== src/lzs_cell.sv =====
`timescale 1ns / 1ps

module lzs_cell #(
   parameter int unsigned LAYER_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lzs_pkg::lzs_op_type           op,
   input  logic [lzs_pkg::LAYER_W-1:0]   look_id,
   input  lzs_pkg::lzs_look_type         look_in,
   output lzs_pkg::lzs_look_type         look_out,
   input  lzs_pkg::lzs_free_type         free_in,
   output lzs_pkg::lzs_free_type         free_out
);
   import lzs_pkg::*;

   localparam logic [LAYER_W-1:0] MY_ID = LAYER_W'(LAYER_IDX);

   logic                         layer_used_ff;
   logic                         layer_used_in;
   logic signed [HEIGHT_W-1:0]   height_ff;
   logic signed [HEIGHT_W-1:0]   height_in;
   logic signed [HEIGHT_X_W-1:0] height_x;
   logic                         in_range;

   // pass the lookup along, replace it when this layer is addressed
   always_comb begin
      look_out = look_in;
      if (look_id == MY_ID) begin
         look_out.used   = layer_used_ff;
         look_out.height = height_ff;
      end
   end

   // keep the lowest free layer found so far
   always_comb begin
      free_out = free_in;
      if (!free_in.found && !layer_used_ff) begin
         free_out.found = 1'b1;
         free_out.idx   = MY_ID;
      end
   end

   always_comb begin
      height_x      = {height_ff[HEIGHT_W-1], height_ff};
      in_range      = layer_used_ff && (height_x >= op.lo) && (height_x <= op.hi);
      layer_used_in = layer_used_ff;
      height_in     = height_ff;
      if (op.tgt_we && (op.tgt_id == MY_ID)) begin
         layer_used_in = op.tgt_used;
         height_in     = op.tgt_height;
      end else if (op.shift_en && in_range) begin
         height_in = op.up ? height_ff + 9'sd1 : height_ff - 9'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_used_ff <= 1'b0;
      end else begin
         layer_used_ff <= layer_used_in;
      end
   end

   always_ff @(posedge clock) begin
      height_ff <= height_in;
   end

endmodule

// ===== src/lzs_group.sv =====
`timescale 1ns / 1ps

module lzs_group #(
   parameter int unsigned BASE_IDX   = 0,
   parameter int unsigned CELL_COUNT = lzs_pkg::GROUP_SIZE
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lzs_pkg::lzs_op_type         op,
   input  logic                        look_en,
   input  logic [lzs_pkg::LAYER_W-1:0] look_id,
   output lzs_pkg::lzs_look_type       look_q,
   output lzs_pkg::lzs_free_type       free_q
);
   import lzs_pkg::*;

   lzs_look_type look_chain [CELL_COUNT+1];
   lzs_free_type free_chain [CELL_COUNT+1];
   lzs_look_type look_ff;
   lzs_look_type look_in;
   lzs_free_type free_ff;

   assign look_chain[0] = '0;
   assign free_chain[0] = '0;

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      lzs_cell #(
         .LAYER_IDX (BASE_IDX + i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .look_id  (look_id),
         .look_in  (look_chain[i]),
         .look_out (look_chain[i+1]),
         .free_in  (free_chain[i]),
         .free_out (free_chain[i+1])
      );
   end

   // hold the lookup for the execute cycle
   assign look_in = look_en ? look_chain[CELL_COUNT] : look_ff;

   always_ff @(posedge clock) begin
      look_ff <= look_in;
      free_ff <= free_chain[CELL_COUNT];
   end

   assign look_q = look_ff;
   assign free_q = free_ff;

endmodule

// ===== src/layer_zorder_stack_manager_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Layer z-order stack manager. Keeps NUM_LAYERS display layers, whether each
// is allocated, and its stacking height (-1 hidden, 0 bottom up to top).
// Commands: allocate (lowest free layer, comes back hidden), set height
// (clamped to -1..top+1, a shown layer to top; layers between old and new
// place shift by one) and free (hide, then release). Code 3 only reports.
// Every command returns one beat: the layer, a pool-full flag, the layer's
// height afterwards and the new top height. Each layer lives in one cell of
// a row; cells are grouped by 16, and each group hands a lookup and a
// lowest-free search from cell to cell, then registers the group result.
// The accept cycle runs the lookup through the cell chains of all groups,
// and the execute cycle, which follows it, clamps the height and broadcasts
// one update that every cell applies at once. The execute cycle holds while
// the previous result beat has not been taken; a new command is accepted
// while a result beat waits. Reset clears the allocation flags directly;
// there is no clearing pass.
module layer_zorder_stack_manager_unit #(
   parameter int unsigned NUM_LAYERS = lzs_pkg::NUM_LAYERS_DEF
) (
   input logic       clock,
   input logic       reset,
   lzs_req_if.sink   req_bus,
   lzs_rsp_if.source rsp_bus
);
   import lzs_pkg::*;

   localparam int unsigned NUM_GROUPS = (NUM_LAYERS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam logic signed [HEIGHT_X_W-1:0] NUM_S = HEIGHT_X_W'(NUM_LAYERS);
   localparam logic signed [HEIGHT_X_W-1:0] X_ZERO = 10'sd0;
   localparam logic signed [HEIGHT_X_W-1:0] X_ONE  = 10'sd1;
   localparam logic signed [HEIGHT_X_W-1:0] X_HIDDEN = -10'sd1;

   // control
   lzs_state_type state_ff;
   lzs_state_type state_in;
   logic          req_fire;
   logic          exec_fire;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic signed [HEIGHT_W-1:0] top_ff;
   logic signed [HEIGHT_W-1:0] top_in;

   // latched command
   lzs_cmd_type                cmd_ff;
   logic [LAYER_W-1:0]         id_ff;
   logic signed [HEIGHT_W-1:0] req_h_ff;

   // result beat
   logic [LAYER_W-1:0]         rsp_layer_ff;
   logic [LAYER_W-1:0]         rsp_layer_in;
   logic                       rsp_full_ff;
   logic                       rsp_full_in;
   logic signed [HEIGHT_W-1:0] rsp_final_ff;
   logic signed [HEIGHT_W-1:0] rsp_final_in;

   // cell row
   lzs_op_type   op;
   lzs_look_type grp_look [NUM_GROUPS];
   lzs_free_type grp_free [NUM_GROUPS];
   lzs_look_type look_sel;
   lzs_free_type alloc_sel;

   // execute datapath
   logic signed [HEIGHT_X_W-1:0] old_x;
   logic signed [HEIGHT_X_W-1:0] top_x;
   logic signed [HEIGHT_X_W-1:0] top_p1;
   logic signed [HEIGHT_X_W-1:0] clamp_h;
   logic signed [HEIGHT_X_W-1:0] new_h;
   logic                         layer_ok;
   logic                         move;
   logic                         top_up;
   logic                         top_dn;

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      localparam int unsigned BASE = g * GROUP_SIZE;
      localparam int unsigned CNT  = (NUM_LAYERS - BASE > GROUP_SIZE) ?
                                     GROUP_SIZE : NUM_LAYERS - BASE;
      lzs_group #(
         .BASE_IDX   (BASE),
         .CELL_COUNT (CNT)
      ) u_group (
         .clock   (clock),
         .reset   (reset),
         .op      (op),
         .look_en (req_fire),
         .look_id (req_bus.layer_id),
         .look_q  (grp_look[g]),
         .free_q  (grp_free[g])
      );
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      exec_fire     = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_EXEC: exec_fire     = !rsp_valid_ff || rsp_bus.ready;
         default: begin
            req_bus.ready = 1'b0;
            exec_fire     = 1'b0;
         end
      endcase
   end

   assign req_fire = req_bus.valid && req_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // -------------------------------------------------- gather group results
   always_comb begin
      look_sel = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         look_sel = look_sel | grp_look[g];
      end
   end

   // lowest group that holds a free layer wins
   always_comb begin
      alloc_sel = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_free[g].found) begin
            alloc_sel = grp_free[g];
         end
      end
   end

   // ----------------------------------------------------- height arithmetic
   always_comb begin
      old_x    = {look_sel.height[HEIGHT_W-1], look_sel.height};
      top_x    = {top_ff[HEIGHT_W-1], top_ff};
      top_p1   = top_x + X_ONE;
      layer_ok = look_sel.used;

      // clamp the request
      clamp_h = {req_h_ff[HEIGHT_W-1], req_h_ff};
      if (clamp_h > top_p1) begin
         clamp_h = top_p1;
      end
      if ((old_x >= X_ZERO) && (clamp_h > top_x)) begin
         clamp_h = top_x;
      end
      if (clamp_h < X_HIDDEN) begin
         clamp_h = X_HIDDEN;
      end
      // showing a layer needs room on the stack
      if ((old_x < X_ZERO) && (clamp_h >= X_ZERO) && (top_p1 >= NUM_S)) begin
         clamp_h = old_x;
      end

      unique case (cmd_ff)
         CMD_SET:  new_h = clamp_h;
         CMD_FREE: new_h = X_HIDDEN;
         CMD_ALLOC,
         CMD_NOP:  new_h = old_x;
         default:  new_h = old_x;
      endcase

      move = layer_ok && ((cmd_ff == CMD_SET) || (cmd_ff == CMD_FREE)) && (new_h != old_x);
   end

   // ------------------------------------------------------- update broadcast
   always_comb begin
      op     = '0;
      top_up = 1'b0;
      top_dn = 1'b0;
      if (move) begin
         if (old_x > new_h) begin
            if (new_h >= X_ZERO) begin
               // lower a shown layer: the ones in between rise
               op.lo = new_h;
               op.hi = old_x - X_ONE;
               op.up = 1'b1;
            end else begin
               // hide: everything above drops
               op.lo  = old_x + X_ONE;
               op.hi  = top_x;
               op.up  = 1'b0;
               top_dn = 1'b1;
            end
         end else begin
            if (old_x >= X_ZERO) begin
               // raise a shown layer: the ones in between drop
               op.lo = old_x + X_ONE;
               op.hi = new_h;
               op.up = 1'b0;
            end else begin
               // show: everything from the new place up rises
               op.lo  = new_h;
               op.hi  = top_x;
               op.up  = 1'b1;
               top_up = 1'b1;
            end
         end
      end
      op.shift_en = exec_fire && move;

      unique case (cmd_ff)
         CMD_ALLOC: begin
            op.tgt_we     = alloc_sel.found;
            op.tgt_id     = alloc_sel.idx;
            op.tgt_used   = 1'b1;
            op.tgt_height = HEIGHT_HIDDEN;
         end
         CMD_SET: begin
            op.tgt_we     = layer_ok;
            op.tgt_id     = id_ff;
            op.tgt_used   = 1'b1;
            op.tgt_height = new_h[HEIGHT_W-1:0];
         end
         CMD_FREE: begin
            op.tgt_we     = layer_ok;
            op.tgt_id     = id_ff;
            op.tgt_used   = 1'b0;
            op.tgt_height = HEIGHT_HIDDEN;
         end
         default: begin
            op.tgt_we     = 1'b0;
            op.tgt_id     = id_ff;
            op.tgt_used   = 1'b0;
            op.tgt_height = HEIGHT_HIDDEN;
         end
      endcase
      op.tgt_we = op.tgt_we && exec_fire;
   end

   // ---------------------------------------------------------- result beat
   always_comb begin
      top_in = top_ff;
      if (exec_fire && top_up) begin
         top_in = top_ff + 9'sd1;
      end else if (exec_fire && top_dn) begin
         top_in = top_ff - 9'sd1;
      end

      rsp_layer_in = id_ff;
      rsp_full_in  = 1'b0;
      rsp_final_in = HEIGHT_HIDDEN;
      unique case (cmd_ff)
         CMD_ALLOC: begin
            rsp_layer_in = alloc_sel.found ? alloc_sel.idx : '0;
            rsp_full_in  = !alloc_sel.found;
         end
         CMD_SET: begin
            if (layer_ok) begin
               rsp_final_in = new_h[HEIGHT_W-1:0];
            end
         end
         CMD_FREE: begin
            rsp_final_in = HEIGHT_HIDDEN;
         end
         CMD_NOP: begin
            if (layer_ok) begin
               rsp_final_in = look_sel.height;
            end
         end
         default: rsp_final_in = HEIGHT_HIDDEN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         top_ff       <= HEIGHT_HIDDEN;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
      end
   end

   // latch the command beat, hold the result until taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= lzs_cmd_type'(req_bus.cmd);
         id_ff    <= req_bus.layer_id;
         req_h_ff <= req_bus.target_height;
      end
      if (exec_fire) begin
         rsp_layer_ff <= rsp_layer_in;
         rsp_full_ff  <= rsp_full_in;
         rsp_final_ff <= rsp_final_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_layer = rsp_layer_ff;
   assign rsp_bus.pool_full    = rsp_full_ff;
   assign rsp_bus.final_height = rsp_final_ff;
   assign rsp_bus.top_height   = top_ff;

   // ------------------------------------------------------------ assertions
   `LZS_ASSERT(a_top_in_range, clock, reset, (top_x >= X_HIDDEN) && (top_x < NUM_S))
   `LZS_ASSERT(a_top_steps_by_one, clock, reset, (!$past(reset) && (top_ff != $past(top_ff))) |-> (({top_ff[HEIGHT_W-1], top_ff} == {$past(top_ff[HEIGHT_W-1]), $past(top_ff)} + X_ONE) || ({top_ff[HEIGHT_W-1], top_ff} == {$past(top_ff[HEIGHT_W-1]), $past(top_ff)} - X_ONE)))
   `LZS_ASSERT(a_rsp_after_exec, clock, reset, (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_EXEC))
   `LZS_ASSERT(a_alloc_in_pool, clock, reset, (!$past(reset) && $rose(rsp_valid_ff) && (cmd_ff == CMD_ALLOC)) |-> (rsp_full_ff || ({2'b00, rsp_layer_ff} < NUM_S)))
   `LZS_NEVER(a_top_moves_only_on_exec, clock, reset, (top_in != top_ff) && !exec_fire)

endmodule
